FILE: rtl/core/xxh64_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh64_pkg
// Constants and helpers shared by the XXH64 stream hasher.
// ----------------------------------------------------------------------------
package xxh64_pkg;

  localparam logic [63:0] P1 = 64'd11400714785074694791;
  localparam logic [63:0] P2 = 64'd14029467366897019727;
  localparam logic [63:0] P3 = 64'd1609587929392839161;
  localparam logic [63:0] P4 = 64'd9650029242287828579;
  localparam logic [63:0] P5 = 64'd2870177450012600261;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
    logic [127:0] t;
    t = {x, x} << r;
    return t[127:64];
  endfunction

endpackage

FILE: rtl/core/xxhash64_stream_hasher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxhash64_stream_hasher_unit
// XXH64 (seed zero) over a stream of little-endian 64-bit words.
// ----------------------------------------------------------------------------
// A word that does not retire a stripe is only stored; a word that retires a
//   stripe needs eight 64-bit multiplies, each three passes through the one
//   shared 32x32 multiplier. Input is not accepted while a word is in process.
// After the last word the hash is formed by the serial multiply chain of
//   merge, tail folds and avalanche;
//   input stays blocked until a pending hash word has been taken.
// Reset: asynchronous, active low; clears lanes, counts and the handshake.
module xxhash64_stream_hasher_unit
  import xxh64_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // [63:0] data_word, [67:64] valid_bytes, pad
  input  logic        s_axis_tlast,  // last_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // [63:0] hash_value
);

  typedef enum logic [4:0] {
    S_IDLE, S_STORE, S_LR_MUL1, S_LR_MUL2, S_LR_WB,
    S_FIN_CHK, S_MERGE, S_MG_MUL1, S_MG_MUL2, S_MG_MUL3, S_MG_NEXT,
    S_ADDLEN, S_T8_MUL1, S_T8_MUL2, S_T8_MUL3,
    S_T4_MUL1, S_T4_MUL2, S_T1_MUL1, S_T1_MUL2,
    S_AV_MUL1, S_AV_MUL2, S_AV_END, S_OUT
  } state_e;

  state_e       state_q;
  logic [63:0]  lane_q [4];
  logic [63:0]  buf_q  [4];
  logic [5:0]   bcnt_q;
  logic [63:0]  len_q;
  logic         used_q;
  logic [63:0]  word_q;
  logic [3:0]   cnt_q;
  logic         last_q;
  logic [1:0]   idx_q;
  logic         stripe_pend_q; // lane round was for stripe consume (vs. store path)
  logic [5:0]   k_q;
  logic [63:0]  h_q;
  logic [63:0]  t_q;
  logic [63:0]  out_q;
  logic         ovalid_q;
  logic [1:0]   mph_q;         // multiply pass
  logic [63:0]  opa_q;
  logic [63:0]  opb_q;
  logic [63:0]  acc_q;

  // shared multiplier: 64x64 low product from three 32x32 passes
  logic [63:0] mul_a, mul_b, mul_p;
  logic [31:0] pp_a, pp_b;
  logic [63:0] pp;
  assign pp_a  = (mph_q == 2'd3) ? opa_q[63:32] : opa_q[31:0];
  assign pp_b  = (mph_q == 2'd2) ? opb_q[63:32] : opb_q[31:0];
  assign pp    = {32'd0, pp_a} * {32'd0, pp_b};
  assign mul_p = acc_q + {pp[31:0], 32'd0};

  logic [63:0] cur_buf;
  logic [7:0]  cur_byte;
  assign cur_buf  = buf_q[k_q[4:3]];
  assign cur_byte = 8'(cur_buf >> {k_q[2:0], 3'b000});

  always_comb begin
    mul_a = t_q;
    mul_b = P1;
    case (state_q)
      S_LR_MUL1: begin mul_a = buf_q[idx_q]; mul_b = P2; end
      S_LR_MUL2: begin mul_a = rotl64(lane_q[idx_q] + t_q, 6'd31); mul_b = P1; end
      S_MG_MUL1: begin mul_a = lane_q[idx_q]; mul_b = P2; end
      S_MG_MUL2: begin mul_a = rotl64(t_q, 6'd31); mul_b = P1; end
      S_MG_MUL3: begin mul_a = h_q ^ t_q; mul_b = P1; end
      S_T8_MUL1: begin mul_a = cur_buf; mul_b = P2; end
      S_T8_MUL2: begin mul_a = rotl64(t_q, 6'd31); mul_b = P1; end
      S_T8_MUL3: begin mul_a = rotl64(h_q ^ t_q, 6'd27); mul_b = P1; end
      S_T4_MUL1: begin mul_a = {32'd0, cur_buf[31:0]}; mul_b = P1; end
      S_T4_MUL2: begin mul_a = rotl64(h_q ^ t_q, 6'd23); mul_b = P2; end
      S_T1_MUL1: begin mul_a = {56'd0, cur_byte}; mul_b = P5; end
      S_T1_MUL2: begin mul_a = rotl64(h_q ^ t_q, 6'd11); mul_b = P1; end
      S_AV_MUL1: begin mul_a = h_q ^ (h_q >> 33); mul_b = P2; end
      S_AV_MUL2: begin mul_a = h_q ^ (h_q >> 29); mul_b = P3; end
      default: ;
    endcase
  end

  logic [3:0] in_cnt;
  always_comb begin
    in_cnt = s_axis_tdata[67:64];
    if (!s_axis_tlast || in_cnt > 4'd8) in_cnt = 4'd8;
  end

  logic [63:0] masked_word;
  always_comb begin
    masked_word = word_q;
    if (cnt_q < 4'd8) masked_word = word_q & ((64'd1 << {cnt_q[2:0], 3'b000}) - 64'd1);
  end

  logic [5:0] bclip;
  assign bclip = (bcnt_q > 6'd32) ? 6'd32 : bcnt_q;
  logic [5:0] rem;
  assign rem = bclip - k_q;

  // multiply states load operands, then make three passes
  logic mul_busy;
  logic mul_done;
  always_comb begin
    case (state_q)
      S_LR_MUL1, S_LR_MUL2, S_MG_MUL1, S_MG_MUL2, S_MG_MUL3,
      S_T8_MUL2, S_T8_MUL3, S_T4_MUL1, S_T4_MUL2, S_T1_MUL1, S_T1_MUL2,
      S_AV_MUL1, S_AV_MUL2: mul_busy = 1'b1;
      S_T8_MUL1: mul_busy = (rem >= 6'd8);
      default: mul_busy = 1'b0;
    endcase
  end
  assign mul_done = mul_busy && (mph_q == 2'd3);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      lane_q[0] <= P1 + P2;
      lane_q[1] <= P2;
      lane_q[2] <= 64'd0;
      lane_q[3] <= 64'd0 - P1;
      bcnt_q   <= '0;
      len_q    <= '0;
      used_q   <= 1'b0;
      ovalid_q <= 1'b0;
      idx_q    <= '0;
      k_q      <= '0;
      stripe_pend_q <= 1'b0;
      mph_q    <= '0;
    end else begin
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      if (mul_busy) begin
        mph_q <= mph_q + 2'd1;
        case (mph_q)
          2'd0: begin opa_q <= mul_a; opb_q <= mul_b; end
          2'd1: acc_q <= pp;
          2'd2: acc_q <= mul_p;
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            word_q  <= s_axis_tdata[63:0];
            cnt_q   <= in_cnt;
            last_q  <= s_axis_tlast;
            state_q <= S_STORE;
            if (in_cnt != 4'd0 && bcnt_q >= 6'd32) begin
              idx_q <= 2'd0;
              stripe_pend_q <= 1'b1;
              state_q <= S_LR_MUL1;
            end
          end
        end
        S_LR_MUL1: if (mul_done) begin t_q <= mul_p; state_q <= S_LR_MUL2; end
        S_LR_MUL2: begin
          if (mul_done) begin
            lane_q[idx_q] <= mul_p;
            idx_q <= idx_q + 2'd1;
            if (idx_q == 2'd3) begin
              used_q <= 1'b1;
              bcnt_q <= '0;
              state_q <= stripe_pend_q ? S_STORE : S_FIN_CHK;
            end else state_q <= S_LR_MUL1;
          end
        end
        S_STORE: begin
          stripe_pend_q <= 1'b0;
          if (cnt_q != 4'd0) begin
            buf_q[bcnt_q[4:3]] <= masked_word;
            bcnt_q <= bcnt_q + 6'(cnt_q);
            len_q  <= len_q + 64'(cnt_q);
          end
          state_q <= last_q ? S_FIN_CHK : S_IDLE;
          if (last_q && cnt_q != 4'd0 && (bcnt_q + 6'(cnt_q)) >= 6'd32) begin
            idx_q <= 2'd0;
            state_q <= S_LR_MUL1;
          end else if (last_q && cnt_q == 4'd0 && bcnt_q >= 6'd32) begin
            idx_q <= 2'd0;
            state_q <= S_LR_MUL1;
          end
        end
        S_FIN_CHK: begin
          k_q <= '0;
          idx_q <= '0;
          if (used_q) state_q <= S_MERGE;
          else begin h_q <= P5; state_q <= S_ADDLEN; end
        end
        S_MERGE: begin
          h_q <= rotl64(lane_q[0], 6'd1) + rotl64(lane_q[1], 6'd7)
               + rotl64(lane_q[2], 6'd12) + rotl64(lane_q[3], 6'd18);
          state_q <= S_MG_MUL1;
        end
        S_MG_MUL1: if (mul_done) begin t_q <= mul_p; state_q <= S_MG_MUL2; end
        S_MG_MUL2: if (mul_done) begin t_q <= mul_p; state_q <= S_MG_MUL3; end
        S_MG_MUL3: if (mul_done) begin h_q <= mul_p + P4; state_q <= S_MG_NEXT; end
        S_MG_NEXT: begin
          idx_q <= idx_q + 2'd1;
          state_q <= (idx_q == 2'd3) ? S_ADDLEN : S_MG_MUL1;
        end
        S_ADDLEN: begin h_q <= h_q + len_q; state_q <= S_T8_MUL1; end
        S_T8_MUL1: begin
          if (rem >= 6'd8) begin
            if (mul_done) begin t_q <= mul_p; state_q <= S_T8_MUL2; end
          end
          else if (rem >= 6'd4) state_q <= S_T4_MUL1;
          else if (rem != 6'd0) state_q <= S_T1_MUL1;
          else state_q <= S_AV_MUL1;
        end
        S_T8_MUL2: if (mul_done) begin t_q <= mul_p; state_q <= S_T8_MUL3; end
        S_T8_MUL3: begin
          if (mul_done) begin
            h_q <= mul_p + P4; k_q <= k_q + 6'd8; state_q <= S_T8_MUL1;
          end
        end
        S_T4_MUL1: if (mul_done) begin t_q <= mul_p; state_q <= S_T4_MUL2; end
        S_T4_MUL2: begin
          if (mul_done) begin
            h_q <= mul_p + P3; k_q <= k_q + 6'd4;
            state_q <= (rem > 6'd4) ? S_T1_MUL1 : S_AV_MUL1;
          end
        end
        S_T1_MUL1: if (mul_done) begin t_q <= mul_p; state_q <= S_T1_MUL2; end
        S_T1_MUL2: begin
          if (mul_done) begin
            h_q <= mul_p; k_q <= k_q + 6'd1;
            state_q <= (rem > 6'd1) ? S_T1_MUL1 : S_AV_MUL1;
          end
        end
        S_AV_MUL1: if (mul_done) begin h_q <= mul_p; state_q <= S_AV_MUL2; end
        S_AV_MUL2: if (mul_done) begin h_q <= mul_p; state_q <= S_AV_END; end
        S_AV_END: begin
          h_q <= h_q ^ (h_q >> 32);
          state_q <= S_OUT;
        end
        S_OUT: begin
          // hash word moves to the output only once the previous one is taken
          if (!ovalid_q) begin
            out_q <= h_q;
            ovalid_q <= 1'b1;
            lane_q[0] <= P1 + P2;
            lane_q[1] <= P2;
            lane_q[2] <= 64'd0;
            lane_q[3] <= 64'd0 - P1;
            bcnt_q <= '0;
            len_q  <= '0;
            used_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The next word waits while a result is pending only through S_OUT; results hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && m_axis_tvalid))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_OUT) |-> (bcnt_q <= 6'd40))
    else $error("buffer count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STORE && !last_q) |=> (state_q == S_IDLE))
    else $error("non-last word did not return to idle");

endmodule

FILE: tb/xxhash64_stream_hasher_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxhash64_stream_hasher_unit_tb
// Self-checking bench for the XXH64 stream hasher. Messages of random length
// and content are streamed in, mostly with random gaps on both sides. An internal
// model computes each digest, and every hash word is compared in order.
// ----------------------------------------------------------------------------
module xxhash64_stream_hasher_unit_tb;
  import xxh64_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 60;
  localparam int unsigned HoldCycles    = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  xxhash64_stream_hasher_unit dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .s_axis_tlast, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #4 clk_i = ~clk_i;

  // model state
  logic [63:0] lanes [4];
  logic [63:0] stripe [4];
  int unsigned held_bytes;
  logic [63:0] msg_len;
  bit          any_stripe;

  logic [63:0] hash_q [$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned sent = 0;
  bit          gaps_on = 1'b1;
  int unsigned sink_hold = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;

  function automatic logic [63:0] rotl(logic [63:0] x, int unsigned r);
    r = r % 64;
    if (r == 0) return x;
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] lane_mix(logic [63:0] acc, logic [63:0] w);
    return rotl(acc + w * P2, 31) * P1;
  endfunction

  task automatic clear_msg();
    lanes[0] = P1 + P2;
    lanes[1] = P2;
    lanes[2] = '0;
    lanes[3] = '0 - P1;
    held_bytes = 0;
    msg_len = '0;
    any_stripe = 1'b0;
  endtask

  task automatic absorb_stripe();
    for (int i = 0; i < 4; i++) lanes[i] = lane_mix(lanes[i], stripe[i]);
    any_stripe = 1'b1;
    held_bytes = 0;
  endtask

  function automatic logic [63:0] digest();
    logic [63:0] h;
    logic [63:0] b8;
    int unsigned k;
    k = 0;
    if (any_stripe) begin
      h = rotl(lanes[0], 1) + rotl(lanes[1], 7) + rotl(lanes[2], 12) + rotl(lanes[3], 18);
      for (int i = 0; i < 4; i++) begin
        h ^= lane_mix('0, lanes[i]);
        h = h * P1 + P4;
      end
    end else begin
      h = P5;
    end
    h += msg_len;
    while (held_bytes - k >= 8) begin
      h ^= lane_mix('0, stripe[k / 8]);
      h = rotl(h, 27) * P1 + P4;
      k += 8;
    end
    if (held_bytes - k >= 4) begin
      h ^= (stripe[k / 8] & 64'hFFFF_FFFF) * P1;
      h = rotl(h, 23) * P2 + P3;
      k += 4;
    end
    while (k < held_bytes) begin
      b8 = (stripe[k / 8] >> (8 * (k % 8))) & 64'hFF;
      h ^= b8 * P5;
      h = rotl(h, 11) * P1;
      k++;
    end
    h ^= h >> 33;
    h *= P2;
    h ^= h >> 29;
    h *= P3;
    h ^= h >> 32;
    return h;
  endfunction

  task automatic predict_word(logic [63:0] w, logic [3:0] cnt, bit last);
    int unsigned n;
    n = (!last || cnt > 8) ? 8 : cnt;
    if (n > 0) begin
      if (held_bytes >= 32) absorb_stripe();
      if (n < 8) w &= (64'd1 << (8 * n)) - 1;
      stripe[held_bytes / 8] = w;
      held_bytes += n;
      msg_len += n;
    end
    if (last) begin
      if (held_bytes >= 32) absorb_stripe();
      hash_q.push_back(digest());
      clear_msg();
    end
  endtask

  // Send one word; predict on acceptance. Valid drops only in a gap or when
  // the sender stops, so back-to-back words keep it high.
  task automatic send_word(logic [63:0] w, logic [3:0] cnt, bit last);
    while (gaps_on && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, cnt, w};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_word(w, cnt, last);
    sent++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_msg(int unsigned nwords, logic [3:0] tail_cnt);
    for (int i = 0; i < nwords; i++)
      send_word(rand64(), 4'($urandom_range(15)), 1'b0);
    send_word(rand64(), tail_cnt, 1'b1);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (hash_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Sink: random ready, with long hold when requested.
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      sink_hold <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= gaps_on ? ($urandom_range(99) >= 24) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (hash_q.size() == 0) begin
        $error("hash_value: unexpected word %h", m_axis_tdata);
        errors++;
      end else begin
        if (m_axis_tdata !== hash_q[0]) begin
          $error("hash_value: expected %h actual %h", hash_q[0], m_axis_tdata);
          errors++;
        end
        void'(hash_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_word(64'h0, 4'd0, 1'b1);                    // empty message
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd4, 1'b1);
    send_word(64'h0123_4567_89AB_CDEF, 4'd7, 1'b1);  // bytes beyond count
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
    send_word(64'hA5A5_A5A5_A5A5_A5A5, 4'd15, 1'b1); // count above eight
    send_word(64'h1111_2222_3333_4444, 4'd3, 1'b0);  // count ignored on a non-last word
    send_word(64'h0, 4'd0, 1'b1);                    // empty last after data
    send_msg(3, 4'd8);                               // exactly one stripe
    send_msg(4, 4'd0);                               // stripe then empty last
    send_msg(4, 4'd5);
    send_msg(7, 4'd8);                               // two stripes
    send_msg(8, 4'd3);
  endtask

  task automatic test_random(int unsigned nitems);
    int unsigned goal;
    goal = sent + nitems;
    while (sent < goal)
      send_msg($urandom_range(99) < 85 ? $urandom_range(12) : $urandom_range(40),
               4'($urandom_range(15)));
  endtask

  task automatic test_no_gaps();
    gaps_on = 1'b0;
    test_random(120);
    gaps_on = 1'b1;
  endtask

  task automatic test_backpressure();
    hold_reqs++;
    for (int i = 0; i < 30; i++) send_msg($urandom_range(3), 4'($urandom_range(8)));
    wait_drained();
  endtask

  initial begin
    clear_msg();
    for (int i = 0; i < 4; i++) stripe[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();
    test_backpressure();
    test_random(300);
    test_no_gaps();
    test_random(250);
    wait_drained();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
